[src/sct_pkg.sv]
// ----------------------------------------------------------------------------
// sct_pkg: shared types and constants of the shell command tokenizer
// Byte codes, the byte class flags, the queue entry and the result record.
// ----------------------------------------------------------------------------
package sct_pkg;

	localparam int MAX_COMMANDS  = 16;
	localparam int MAX_ARGUMENTS = 64;

	localparam int CMD_W = 4;
	localparam int ARG_W = 6;

	// Counts stop at the smaller of the configured limit and the field range.
	localparam int CMD_LIMIT_I = ((MAX_COMMANDS - 1) < 15) ? (MAX_COMMANDS - 1) : 15;
	localparam int ARG_LIMIT_I = ((MAX_ARGUMENTS - 1) < 63) ? (MAX_ARGUMENTS - 1) : 63;
	localparam logic [CMD_W-1:0] CMD_LIMIT = CMD_W'(CMD_LIMIT_I);
	localparam logic [ARG_W-1:0] ARG_LIMIT = ARG_W'(ARG_LIMIT_I);

	localparam logic [7:0] CHAR_SQUOTE = 8'h27;
	localparam logic [7:0] CHAR_DQUOTE = 8'h22;
	localparam logic [7:0] CHAR_BSLASH = 8'h5C;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_PIPE   = 8'h7C;
	localparam logic [7:0] CHAR_AMP    = 8'h26;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic squote;
		logic dquote;
		logic bslash;
		logic space;
		logic pipe;
		logic amp;
	} sct_class_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       line_end;
		sct_class_t cls;
	} sct_entry_t;

	typedef struct packed {
		logic             char_valid;
		logic [7:0]       char_out;
		logic             end_of_arg;
		logic             end_of_command;
		logic             background;
		logic [CMD_W-1:0] command_index;
		logic [ARG_W-1:0] arg_index;
		logic             last;
	} sct_result_t;

	function automatic sct_class_t sct_classify(input logic [7:0] ch);
		sct_class_t c;
		c.squote = (ch == CHAR_SQUOTE);
		c.dquote = (ch == CHAR_DQUOTE);
		c.bslash = (ch == CHAR_BSLASH);
		c.space  = (ch == CHAR_SPACE);
		c.pipe   = (ch == CHAR_PIPE);
		c.amp    = (ch == CHAR_AMP);
		return c;
	endfunction

endpackage

[src/sct_in_if.sv]
// ----------------------------------------------------------------------------
// sct_in_if: command line byte channel
// Carries one byte of the line and its line end mark per transaction.
// ----------------------------------------------------------------------------
interface sct_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       line_end;

	modport source (output valid, output char_in, output line_end, input ready);
	modport sink (input valid, input char_in, input line_end, output ready);
endinterface

[src/sct_out_if.sv]
// ----------------------------------------------------------------------------
// sct_out_if: token channel
// Carries one argument byte or boundary mark per transaction.
// ----------------------------------------------------------------------------
interface sct_out_if;
	logic       valid;
	logic       ready;
	logic       char_valid;
	logic [7:0] char_out;
	logic       end_of_arg;
	logic       end_of_command;
	logic       background;
	logic [3:0] command_index;
	logic [5:0] arg_index;
	logic       last;

	modport source (output valid, output char_valid, output char_out, output end_of_arg,
		output end_of_command, output background, output command_index,
		output arg_index, output last, input ready);
	modport sink (input valid, input char_valid, input char_out, input end_of_arg,
		input end_of_command, input background, input command_index,
		input arg_index, input last, output ready);
endinterface

[src/sct_front.sv]
// ----------------------------------------------------------------------------
// sct_front: byte intake and classification
// Tags each incoming byte with its class flags and pushes it into the queue.
// ----------------------------------------------------------------------------
module sct_front import sct_pkg::*; (
	sct_in_if.sink     rx,
	output logic       push_valid,
	input  logic       push_ready,
	output sct_entry_t push_data
);

	assign rx.ready   = push_ready;
	assign push_valid = rx.valid;

	always_comb begin
		push_data.ch       = rx.char_in;
		push_data.line_end = rx.line_end;
		// The terminating byte is never tokenized, so it carries no class.
		push_data.cls      = rx.line_end ? '0 : sct_classify(rx.char_in);
	end

endmodule

[src/sct_queue.sv]
// ----------------------------------------------------------------------------
// sct_queue: short queue between the front and back parts
// A small circular buffer that can push and pop in the same cycle; a full queue takes no push.
// ----------------------------------------------------------------------------
module sct_queue import sct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push_valid,
	output logic       push_ready,
	input  sct_entry_t push_data,
	output logic       pop_valid,
	input  logic       pop_ready,
	output sct_entry_t pop_data
);

	sct_entry_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) count_q <= QCNT_W'(QUEUE_DEPTH);
	endproperty
	assert property (p_no_overflow) else $error("queue count above depth");

	property p_count_tracks;
		@(posedge clk) disable iff (!arst_n)
			(push && !pop) |=> (count_q == $past(count_q) + 1'b1);
	endproperty
	assert property (p_count_tracks) else $error("queue count did not advance on push");

	property p_empty_ptrs;
		@(posedge clk) disable iff (!arst_n) (count_q == '0) |-> (wr_ptr_q == rd_ptr_q);
	endproperty
	assert property (p_empty_ptrs) else $error("empty queue with unequal pointers");

endmodule

[src/sct_back.sv]
// ----------------------------------------------------------------------------
// sct_back: tokenizer state and result register
// Applies quote, escape and split rules to each queued byte and drives results.
// ----------------------------------------------------------------------------
module sct_back import sct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pop_valid,
	output logic       pop_ready,
	input  sct_entry_t pop_data,
	sct_out_if.source  tx
);

	logic             sq_q, dq_q, esc_q;
	logic             tok_open_q, tok_quoted_q;
	logic             held_valid_q, held_first_q;
	logic [7:0]       held_byte_q;
	sct_class_t       held_cls_q;
	logic [CMD_W-1:0] cmd_q;
	logic [ARG_W-1:0] arg_q;
	logic             line_done_q;

	logic             n_sq, n_dq, n_esc;
	logic             n_tok_open, n_tok_quoted;
	logic             n_held_valid, n_held_first;
	logic [7:0]       n_held_byte;
	sct_class_t       n_held_cls;
	logic [CMD_W-1:0] n_cmd;
	logic [ARG_W-1:0] n_arg;
	logic             n_line_done;

	logic             out_valid_q;
	sct_result_t      out_q;

	sct_result_t      res;
	logic             has_res;
	logic             pop;
	logic             unq;
	logic             do_finish, do_token, fin_cmd, fin_end;
	logic             clr_line, set_done, cv;
	logic             held_quote;

	// A new item is taken whenever the result register is free or being drained.
	assign pop_ready = !out_valid_q || tx.ready;
	assign pop       = pop_valid && pop_ready;

	always_comb begin
		n_sq         = sq_q;
		n_dq         = dq_q;
		n_esc        = esc_q;
		n_tok_open   = tok_open_q;
		n_tok_quoted = tok_quoted_q;
		n_held_valid = held_valid_q;
		n_held_first = held_first_q;
		n_held_byte  = held_byte_q;
		n_held_cls   = held_cls_q;
		n_cmd        = cmd_q;
		n_arg        = arg_q;
		n_line_done  = line_done_q;

		res               = '0;
		res.command_index = cmd_q;
		res.arg_index     = arg_q;
		has_res           = 1'b0;
		do_finish         = 1'b0;
		do_token          = 1'b0;
		fin_cmd           = 1'b0;
		fin_end           = 1'b0;
		clr_line          = 1'b0;
		set_done          = 1'b0;
		cv                = 1'b0;
		unq               = !sq_q && !dq_q && !esc_q;
		held_quote        = held_cls_q.squote || held_cls_q.dquote;

		if (line_done_q) begin
			// After a lone ampersand the rest of the line is dropped.
			clr_line = pop_data.line_end;
		end else if (pop_data.line_end) begin
			do_finish = 1'b1;
			fin_cmd   = 1'b1;
			fin_end   = 1'b1;
		end else begin
			do_token = 1'b1;
			if (pop_data.cls.squote && !dq_q && !esc_q) begin
				n_sq = !sq_q;
			end else if (pop_data.cls.dquote && !sq_q && !esc_q) begin
				n_dq = !dq_q;
			end else if (pop_data.cls.bslash && !esc_q) begin
				n_esc = 1'b1;
			end else if (pop_data.cls.space && unq) begin
				do_token  = 1'b0;
				do_finish = 1'b1;
			end else if (pop_data.cls.pipe && unq) begin
				do_token  = 1'b0;
				do_finish = 1'b1;
				fin_cmd   = 1'b1;
			end else begin
				n_esc = 1'b0;
			end
		end

		if (do_finish) begin
			if (tok_open_q && held_valid_q && held_first_q && !tok_quoted_q &&
				held_cls_q.amp) begin
				has_res            = 1'b1;
				res.end_of_command = 1'b1;
				res.background     = 1'b1;
				res.last           = 1'b1;
				clr_line           = 1'b1;
				set_done           = !fin_end;
			end else if (tok_open_q || fin_cmd) begin
				cv = held_valid_q && (tok_quoted_q ? !held_quote : !held_cls_q.bslash);
				has_res            = 1'b1;
				res.char_valid     = cv;
				res.char_out       = cv ? held_byte_q : 8'h00;
				res.end_of_arg     = tok_open_q;
				res.end_of_command = fin_cmd;
				res.last           = fin_end;
				if (tok_open_q && (arg_q < ARG_LIMIT)) begin
					n_arg = arg_q + 1'b1;
				end
				n_tok_open   = 1'b0;
				n_tok_quoted = 1'b0;
				n_held_valid = 1'b0;
				n_held_first = 1'b0;
				if (fin_cmd) begin
					if (cmd_q < CMD_LIMIT) begin
						n_cmd = cmd_q + 1'b1;
					end
					n_arg = '0;
					n_sq  = 1'b0;
					n_dq  = 1'b0;
					n_esc = 1'b0;
				end
				clr_line = fin_end;
			end
		end else if (do_token) begin
			if (!tok_open_q) begin
				n_tok_open = 1'b1;
				if (pop_data.cls.squote || pop_data.cls.dquote) begin
					n_tok_quoted = 1'b1;
				end else begin
					n_held_valid = 1'b1;
					n_held_byte  = pop_data.ch;
					n_held_cls   = pop_data.cls;
					n_held_first = 1'b1;
				end
			end else begin
				// The previous byte goes out now; the new one is held back.
				cv = held_valid_q && (tok_quoted_q || !held_cls_q.bslash);
				has_res        = cv;
				res.char_valid = 1'b1;
				res.char_out   = held_byte_q;
				n_held_valid   = 1'b1;
				n_held_byte    = pop_data.ch;
				n_held_cls     = pop_data.cls;
				n_held_first   = 1'b0;
			end
		end

		if (clr_line) begin
			n_sq         = 1'b0;
			n_dq         = 1'b0;
			n_esc        = 1'b0;
			n_tok_open   = 1'b0;
			n_tok_quoted = 1'b0;
			n_held_valid = 1'b0;
			n_held_first = 1'b0;
			n_cmd        = '0;
			n_arg        = '0;
			n_line_done  = set_done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q         <= 1'b0;
			dq_q         <= 1'b0;
			esc_q        <= 1'b0;
			tok_open_q   <= 1'b0;
			tok_quoted_q <= 1'b0;
			held_valid_q <= 1'b0;
			held_first_q <= 1'b0;
			cmd_q        <= '0;
			arg_q        <= '0;
			line_done_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				sq_q         <= n_sq;
				dq_q         <= n_dq;
				esc_q        <= n_esc;
				tok_open_q   <= n_tok_open;
				tok_quoted_q <= n_tok_quoted;
				held_valid_q <= n_held_valid;
				held_first_q <= n_held_first;
				cmd_q        <= n_cmd;
				arg_q        <= n_arg;
				line_done_q  <= n_line_done;
			end
			if (pop && has_res) begin
				out_valid_q <= 1'b1;
			end else if (tx.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			held_byte_q <= n_held_byte;
			held_cls_q  <= n_held_cls;
		end
		if (pop && has_res) begin
			out_q <= res;
		end
	end

	assign tx.valid          = out_valid_q;
	assign tx.char_valid     = out_q.char_valid;
	assign tx.char_out       = out_q.char_out;
	assign tx.end_of_arg     = out_q.end_of_arg;
	assign tx.end_of_command = out_q.end_of_command;
	assign tx.background     = out_q.background;
	assign tx.command_index  = out_q.command_index;
	assign tx.arg_index      = out_q.arg_index;
	assign tx.last           = out_q.last;

	property p_last_clears_counts;
		@(posedge clk) disable iff (!arst_n)
			(pop && has_res && res.last) |=> (cmd_q == '0 && arg_q == '0 && !tok_open_q);
	endproperty
	assert property (p_last_clears_counts) else $error("line state not cleared after last");

	property p_held_needs_token;
		@(posedge clk) disable iff (!arst_n) held_valid_q |-> tok_open_q;
	endproperty
	assert property (p_held_needs_token) else $error("held byte outside an argument");

	property p_counts_saturate;
		@(posedge clk) disable iff (!arst_n) (cmd_q <= CMD_LIMIT) && (arg_q <= ARG_LIMIT);
	endproperty
	assert property (p_counts_saturate) else $error("count above its limit");

	property p_done_is_silent;
		@(posedge clk) disable iff (!arst_n) (line_done_q && pop) |-> !has_res;
	endproperty
	assert property (p_done_is_silent) else $error("result produced in a discarded line");

endmodule

[src/shell_command_tokenizer.sv]
// ----------------------------------------------------------------------------
// shell_command_tokenizer: streaming shell command line tokenizer
// Splits a byte stream into arguments and piped commands.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while its queue has room and gives
// at most one transaction per byte: an argument byte with quotes and
// backslashes removed, or a mark that closes an argument, a command or the
// line. Argument bytes come out one byte late, since the last byte of each
// argument is held back to drop a trailing quote and to spot a lone ampersand.
// A byte passes the classifier, a two-entry queue, the state update of the
// back end and its result register, so a result is offered once its byte has
// been written into the queue and then into the result register; the back
// end's state update sets the sustained rate of one byte per cycle while the
// output side keeps taking transactions.
module shell_command_tokenizer import sct_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sct_in_if.sink    rx,
	sct_out_if.source tx
);

	logic       push_valid;
	logic       push_ready;
	sct_entry_t push_data;
	logic       pop_valid;
	logic       pop_ready;
	sct_entry_t pop_data;

	sct_front u_front (
		.rx         (rx),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	sct_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	sct_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.tx        (tx)
	);

endmodule

[sim/tb_shell_command_tokenizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shell_command_tokenizer: self-checking bench for the command line tokenizer
// Walks a short table of hand-picked lines, then well-formed and noisy random
// lines. A behavioral tokenizer predicts every token transaction, and each
// transaction that leaves the block is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_shell_command_tokenizer;
	import sct_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 10;
	localparam int RANDOM_ITEMS = 1500;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		logic [7:0]  ch;
		logic        le;
		logic        pinned;
		logic        pin_has;
		sct_result_t pin_tok;
	} stim_row_t;

	localparam sct_result_t NO_TOK = '0;

	localparam logic [7:0] SPECIALS [6] = '{CHAR_SQUOTE, CHAR_DQUOTE, CHAR_BSLASH,
		CHAR_SPACE, CHAR_PIPE, CHAR_AMP};

	localparam int N_DIRECTED = 28;
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		// An empty line right after reset still closes a command and the line.
		'{8'h00, 1'b1, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 4'd0, 6'd0, 1'b1}},
		'{"a", 1'b0, 1'b1, 1'b0, NO_TOK},
		'{"b", 1'b0, 1'b1, 1'b1, '{1'b1, "a", 1'b0, 1'b0, 1'b0, 4'd0, 6'd0, 1'b0}},
		'{CHAR_PIPE, 1'b0, 1'b1, 1'b1, '{1'b1, "b", 1'b1, 1'b1, 1'b0, 4'd0, 6'd0, 1'b0}},
		'{8'hFF, 1'b0, 1'b0, 1'b0, NO_TOK},
		'{8'h00, 1'b0, 1'b0, 1'b0, NO_TOK},
		'{CHAR_SPACE, 1'b0, 1'b0, 1'b0, NO_TOK},
		'{CHAR_DQUOTE, 1'b0, 1'b0, 1'b0, NO_TOK},
		'{"q", 1'b0, 1'b0, 1'b0, NO_TOK},
		'{CHAR_DQUOTE, 1'b0, 1'b0, 1'b0, NO_TOK},
		'{CHAR_SPACE, 1'b0, 1'b0, 1'b0, NO_TOK},
		// A backslash escapes a quote even inside single quotes.
		'{CHAR_SQUOTE, 1'b0, 1'b0, 1'b0, NO_TOK},
		'{CHAR_BSLASH, 1'b0, 1'b0, 1'b0, NO_TOK},
		'{CHAR_SQUOTE, 1'b0, 1'b0, 1'b0, NO_TOK},
		'{CHAR_SQUOTE, 1'b0, 1'b0, 1'b0, NO_TOK},
		'{CHAR_SPACE, 1'b0, 1'b0, 1'b0, NO_TOK},
		'{CHAR_BSLASH, 1'b0, 1'b0, 1'b0, NO_TOK},
		'{"x", 1'b0, 1'b0, 1'b0, NO_TOK},
		'{CHAR_PIPE, 1'b0, 1'b0, 1'b0, NO_TOK},
		// A lone ampersand puts the line in the background; the rest is dropped.
		'{CHAR_AMP, 1'b0, 1'b0, 1'b0, NO_TOK},
		'{CHAR_SPACE, 1'b0, 1'b0, 1'b0, NO_TOK},
		'{"z", 1'b0, 1'b0, 1'b0, NO_TOK},
		'{8'h0A, 1'b1, 1'b0, 1'b0, NO_TOK},
		// A lone quote argument closes as an empty argument.
		'{CHAR_SQUOTE, 1'b0, 1'b0, 1'b0, NO_TOK},
		'{8'h0A, 1'b1, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b1, 1'b1, 1'b0, 4'd0, 6'd0, 1'b1}},
		'{CHAR_PIPE, 1'b0, 1'b1, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 4'd0, 6'd0, 1'b0}},
		'{CHAR_BSLASH, 1'b0, 1'b0, 1'b0, NO_TOK},
		'{8'h00, 1'b1, 1'b0, 1'b0, NO_TOK}
	};

	logic clk;
	logic arst_n;

	sct_in_if  rx_if ();
	sct_out_if tx_if ();

	shell_command_tokenizer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	stim_row_t   line_bytes [$];
	sct_result_t pending_tokens [$];
	int          errors;
	int          sent;
	int          send_idle_pct;
	int          recv_idle_pct;

	// Tokenizer state as the predictor sees it.
	bit               in_sq, in_dq, esc_pending;
	bit               tok_open, tok_quoted;
	bit               held_valid, held_first, discarding;
	logic [7:0]       held_byte;
	logic [CMD_W-1:0] cmd_count;
	logic [ARG_W-1:0] arg_cnt;

	function automatic void drop_token();
		tok_open   = 1'b0;
		tok_quoted = 1'b0;
		held_valid = 1'b0;
		held_byte  = 8'h00;
		held_first = 1'b0;
	endfunction

	function automatic void drop_line();
		in_sq       = 1'b0;
		in_dq       = 1'b0;
		esc_pending = 1'b0;
		drop_token();
		cmd_count  = '0;
		arg_cnt    = '0;
		discarding = 1'b0;
	endfunction

	function automatic sct_result_t make_tok(bit cv, logic [7:0] ch, bit eoa, bit eoc, bit bg,
			bit lst);
		sct_result_t r;
		r.char_valid     = cv;
		r.char_out       = ch;
		r.end_of_arg     = eoa;
		r.end_of_command = eoc;
		r.background     = bg;
		r.command_index  = cmd_count;
		r.arg_index      = arg_cnt;
		r.last           = lst;
		return r;
	endfunction

	// Closes the open argument and, when asked, the command and the line.
	function automatic bit close_arg(input bit cmd_end, input bit at_end,
			output sct_result_t r);
		bit cv;
		r = '0;
		if (tok_open && held_valid && held_first && !tok_quoted && held_byte == CHAR_AMP) begin
			r = make_tok(1'b0, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
			drop_line();
			if (!at_end)
				discarding = 1'b1;
			return 1'b1;
		end
		if (!tok_open && !cmd_end)
			return 1'b0;
		cv = held_valid && (tok_quoted ? !(held_byte == CHAR_SQUOTE || held_byte == CHAR_DQUOTE)
		                               : held_byte != CHAR_BSLASH);
		r = make_tok(cv, cv ? held_byte : 8'h00, tok_open, cmd_end, 1'b0, at_end);
		if (tok_open && arg_cnt < ARG_LIMIT)
			arg_cnt++;
		drop_token();
		if (cmd_end) begin
			if (cmd_count < CMD_LIMIT)
				cmd_count++;
			arg_cnt     = '0;
			in_sq       = 1'b0;
			in_dq       = 1'b0;
			esc_pending = 1'b0;
		end
		if (at_end)
			drop_line();
		return 1'b1;
	endfunction

	function automatic bit tokenize_byte(input logic [7:0] c, input bit le,
			output sct_result_t r);
		bit         unq;
		bit         cv;
		logic [7:0] prev;
		r   = '0;
		unq = !in_sq && !in_dq && !esc_pending;
		if (discarding) begin
			if (le)
				drop_line();
			return 1'b0;
		end
		if (le)
			return close_arg(1'b1, 1'b1, r);
		if (c == CHAR_SQUOTE && !in_dq && !esc_pending)
			in_sq = !in_sq;
		else if (c == CHAR_DQUOTE && !in_sq && !esc_pending)
			in_dq = !in_dq;
		else if (c == CHAR_BSLASH && !esc_pending)
			esc_pending = 1'b1;
		else if (c == CHAR_SPACE && unq)
			return close_arg(1'b0, 1'b0, r);
		else if (c == CHAR_PIPE && unq)
			return close_arg(1'b1, 1'b0, r);
		else
			esc_pending = 1'b0;

		if (!tok_open) begin
			tok_open = 1'b1;
			if (c == CHAR_SQUOTE || c == CHAR_DQUOTE) begin
				tok_quoted = 1'b1;
			end else begin
				held_valid = 1'b1;
				held_byte  = c;
				held_first = 1'b1;
			end
			return 1'b0;
		end
		// The held byte goes out now and the new byte takes its place.
		cv         = held_valid && (tok_quoted || held_byte != CHAR_BSLASH);
		prev       = held_byte;
		held_valid = 1'b1;
		held_byte  = c;
		held_first = 1'b0;
		if (!cv)
			return 1'b0;
		r = make_tok(1'b1, prev, 1'b0, 1'b0, 1'b0, 1'b0);
		return 1'b1;
	endfunction

	function automatic string tok_text(sct_result_t r);
		return $sformatf("cv=%0b ch=%02h eoa=%0b eoc=%0b bg=%0b cmd=%0d arg=%0d last=%0b",
			r.char_valid, r.char_out, r.end_of_arg, r.end_of_command, r.background,
			r.command_index, r.arg_index, r.last);
	endfunction

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endfunction

	function automatic void push_byte(logic [7:0] c, bit le);
		stim_row_t row;
		row = '{c, le, 1'b0, 1'b0, NO_TOK};
		line_bytes.push_back(row);
	endfunction

	// Any byte that does not steer quoting or splitting.
	function automatic logic [7:0] word_byte();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		if (c == CHAR_SQUOTE || c == CHAR_DQUOTE || c == CHAR_BSLASH || c == CHAR_SPACE ||
				c == CHAR_PIPE)
			c = 8'h61 + 8'($urandom_range(0, 25));
		return c;
	endfunction

	// A big line adds no lone ampersand of its own, so its counters can run to their limits.
	function automatic void add_arg(input bit big);
		int         n;
		logic [7:0] q;
		n = $urandom_range(1, 4);
		case ($urandom_range(0, 9))
			5, 6: begin
				q = $urandom_range(0, 1) ? CHAR_SQUOTE : CHAR_DQUOTE;
				push_byte(q, 1'b0);
				repeat (n - 1) begin
					case ($urandom_range(0, 5))
						0: push_byte(CHAR_SPACE, 1'b0);
						1: push_byte(CHAR_PIPE, 1'b0);
						2: begin
							push_byte(CHAR_BSLASH, 1'b0);
							push_byte(8'($urandom_range(0, 255)), 1'b0);
						end
						default: push_byte(word_byte(), 1'b0);
					endcase
				end
				push_byte(q, 1'b0);
			end
			7: begin
				push_byte(CHAR_BSLASH, 1'b0);
				push_byte(8'($urandom_range(0, 255)), 1'b0);
				repeat (n - 1) push_byte(word_byte(), 1'b0);
			end
			8: begin
				push_byte(word_byte(), 1'b0);
				push_byte(CHAR_AMP, 1'b0);
				repeat (n - 1) push_byte(word_byte(), 1'b0);
			end
			9: begin
				if (!big && $urandom_range(0, 3) == 0)
					push_byte(CHAR_AMP, 1'b0);
				else
					push_byte(word_byte(), 1'b0);
			end
			default: begin
				repeat (n) begin
					if ($urandom_range(0, 7) == 0)
						push_byte(CHAR_BSLASH, 1'b0);
					push_byte(word_byte(), 1'b0);
				end
			end
		endcase
	endfunction

	// A big line has enough commands and arguments to pin both counters.
	function automatic void add_line(bit big);
		int n_cmds;
		int n_args;
		if (!big && $urandom_range(0, 99) < 20) begin
			repeat ($urandom_range(1, 30))
				push_byte($urandom_range(0, 1) ? SPECIALS[$urandom_range(0, 5)]
				                               : 8'($urandom_range(0, 255)), 1'b0);
		end else begin
			n_cmds = big ? 18 : (($urandom_range(0, 19) == 0) ? $urandom_range(16, 20)
			                                                  : $urandom_range(1, 3));
			for (int ci = 0; ci < n_cmds; ci++) begin
				n_args = ((big && ci == 0) || $urandom_range(0, 59) == 0) ?
					$urandom_range(64, 70) : $urandom_range(1, 4);
				for (int ai = 0; ai < n_args; ai++) begin
					repeat ($urandom_range(ai == 0 ? 0 : 1, 3)) push_byte(CHAR_SPACE, 1'b0);
					add_arg(big);
				end
				repeat ($urandom_range(0, 2)) push_byte(CHAR_SPACE, 1'b0);
				if (ci < n_cmds - 1)
					push_byte(CHAR_PIPE, 1'b0);
			end
		end
		push_byte(8'($urandom_range(0, 255)), 1'b1);
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Input side: builds the line bytes, offers them and predicts each accepted one.
	initial begin
		int          total;
		bit          has_tok;
		sct_result_t tok;
		errors        = 0;
		sent          = 0;
		send_idle_pct = 26;
		recv_idle_pct = 65;
		arst_n          <= 1'b0;
		rx_if.valid     <= 1'b0;
		rx_if.char_in   <= 8'h00;
		rx_if.line_end  <= 1'b0;
		drop_line();
		foreach (DIRECTED[i])
			line_bytes.push_back(DIRECTED[i]);
		add_line(1'b1);
		while (line_bytes.size() < N_DIRECTED + RANDOM_ITEMS)
			add_line(1'b0);
		total = line_bytes.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (sent < total) begin
			@(posedge clk);
			if (rx_if.valid && rx_if.ready) begin
				has_tok = tokenize_byte(line_bytes[sent].ch, line_bytes[sent].le, tok);
				if (line_bytes[sent].pinned) begin
					has_tok = line_bytes[sent].pin_has;
					tok     = line_bytes[sent].pin_tok;
				end
				if (has_tok)
					pending_tokens.push_back(tok);
				sent++;
				if (sent == total / 3) begin
					send_idle_pct = 65;
					recv_idle_pct = 26;
				end else if (sent == 2 * total / 3) begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			end
			if (!rx_if.valid || rx_if.ready) begin
				if (sent < total && $urandom_range(0, 99) >= send_idle_pct) begin
					rx_if.valid    <= 1'b1;
					rx_if.char_in  <= line_bytes[sent].ch;
					rx_if.line_end <= line_bytes[sent].le;
				end else begin
					rx_if.valid <= 1'b0;
				end
			end
		end

		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Output side: checks each token transaction and throttles ready.
	initial begin
		int          hold_left;
		bit          pressure_done;
		sct_result_t got;
		sct_result_t want;
		hold_left     = 0;
		pressure_done = 1'b0;
		tx_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (tx_if.valid && tx_if.ready) begin
				got.char_valid     = tx_if.char_valid;
				got.char_out       = tx_if.char_out;
				got.end_of_arg     = tx_if.end_of_arg;
				got.end_of_command = tx_if.end_of_command;
				got.background     = tx_if.background;
				got.command_index  = tx_if.command_index;
				got.arg_index      = tx_if.arg_index;
				got.last           = tx_if.last;
				if (pending_tokens.size() == 0) begin
					flag_error($sformatf("unexpected transaction: %s", tok_text(got)));
				end else begin
					want = pending_tokens.pop_front();
					if (got.char_valid !== want.char_valid || got.char_out !== want.char_out ||
							got.end_of_arg !== want.end_of_arg ||
							got.end_of_command !== want.end_of_command ||
							got.background !== want.background ||
							got.command_index !== want.command_index ||
							got.arg_index !== want.arg_index || got.last !== want.last)
						flag_error($sformatf("expected %s, got %s", tok_text(want),
							tok_text(got)));
				end
			end
			// One long hold late in the run lets the block fill and push back on its input.
			if (!pressure_done && sent >= (N_DIRECTED + RANDOM_ITEMS) * 5 / 6) begin
				hold_left     = HOLD_CYCLES;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				tx_if.ready <= 1'b0;
			end else begin
				tx_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// Ends the run when no transaction moves on either side for too long.
	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
